/* rtl/vdr_pkg.sv */
package vdr_pkg;

  localparam int unsigned MAX_VERTICES = 1024;

  // Widest cell number over the whole parameter range (65536 cells).
  localparam int unsigned ID_W = 16;
  localparam int unsigned MERGED_ID_W = 10;
  localparam int unsigned INDEX_W = 24;
  localparam int unsigned COORD_W = 32;

  typedef logic [ID_W-1:0] id_t;
  typedef logic [3*COORD_W-1:0] key_t;

  typedef struct packed {
    logic               first_of_mesh;
    logic [COORD_W-1:0] vertex_x;
    logic [COORD_W-1:0] vertex_y;
    logic [COORD_W-1:0] vertex_z;
    logic [INDEX_W-1:0] source_index;
  } item_t;

  typedef struct packed {
    logic [MERGED_ID_W-1:0] merged_id;
    logic                   is_new;
    logic [INDEX_W-1:0]     kept_index;
    logic                   overflow;
  } result_t;

  // One lookup in flight, moving one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic               clear;
    logic               done;
    logic               is_new;
    id_t                id;
    key_t               key;
    logic [INDEX_W-1:0] src;
  } tok_t;

  // Fold -0 onto +0 so that keys compare bit for bit.
  function automatic logic [COORD_W-1:0] canon_coord(input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] r;
    r = b;
    if (b[COORD_W-2:0] == '0) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

/* rtl/vertex_dedup_index_remap.sv */
// Channel   Handshake           Payload              Direction
// item      start / busy        vdr_pkg::item_t      in
// result    strobe              vdr_pkg::result_t    out
//
// One item is taken every cycle that start is high and busy is low; busy is high only while rst is high.
// Each lookup walks the cell chain, one cell per cycle, and its result
// is registered in the head register and then in every cell before it reaches the ports.
// Reset empties every cell at once and drops lookups in flight.
// The receiver cannot stall: each result is on the ports for one cycle.
module vertex_dedup_index_remap #(
  parameter int unsigned MaxVertices = vdr_pkg::MAX_VERTICES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vdr_pkg::item_t   item,
  output logic             strobe,
  output vdr_pkg::result_t result
);

  vdr_pkg::tok_t stage [0:MaxVertices];
  vdr_pkg::tok_t head;
  vdr_pkg::tok_t tok_next;
  logic          accept;

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    tok_next.valid  = accept;
    tok_next.clear  = item.first_of_mesh;
    tok_next.done   = 1'b0;
    tok_next.is_new = 1'b0;
    tok_next.id     = '0;
    tok_next.key    = {vdr_pkg::canon_coord(item.vertex_x),
                       vdr_pkg::canon_coord(item.vertex_y),
                       vdr_pkg::canon_coord(item.vertex_z)};
    tok_next.src    = item.source_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= tok_next;
    end
  end

  assign stage[0] = head;

  for (genvar i = 0; i < MaxVertices; i++) begin : g_cell
    vdr_cell #(
      .Idx(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (stage[i]),
      .tok_out(stage[i+1])
    );
  end

  // A lookup that leaves the chain unclaimed found every cell full.
  always_comb begin
    strobe            = stage[MaxVertices].valid;
    result.merged_id  = stage[MaxVertices].done ?
                        stage[MaxVertices].id[vdr_pkg::MERGED_ID_W-1:0] : '0;
    result.is_new     = stage[MaxVertices].done && stage[MaxVertices].is_new;
    result.kept_index = result.is_new ? stage[MaxVertices].src : '0;
    result.overflow   = !stage[MaxVertices].done;
  end

  a_new_not_overflow: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(result.is_new && result.overflow))
    else $error("result both new and overflow");

  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && result.overflow |-> result.merged_id == '0 && result.kept_index == '0)
    else $error("overflow result carries id or index");

  a_first_takes_zero: assert property (@(posedge clk) disable iff (rst)
    stage[0].valid && stage[0].clear |=> stage[1].valid && stage[1].is_new &&
    stage[1].id == '0)
    else $error("first item of mesh did not take cell zero");

endmodule

/* rtl/vdr_cell.sv */
module vdr_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  vdr_pkg::tok_t tok_in,
  output vdr_pkg::tok_t tok_out
);

  vdr_pkg::key_t key;
  logic          occupied;
  logic          occ_next;
  logic          occ_eff;
  logic          key_write;
  vdr_pkg::tok_t tok_next;

  always_comb begin
    tok_next  = tok_in;
    occ_next  = occupied;
    key_write = 1'b0;
    // A first-of-mesh lookup empties every cell it passes but the first, where it takes its vertex.
    occ_eff   = occupied && !tok_in.clear;
    if (tok_in.valid) begin
      occ_next = occ_eff;
      if (!tok_in.done) begin
        if (!occ_eff) begin
          // First free cell: take the vertex here.
          key_write       = 1'b1;
          occ_next        = 1'b1;
          tok_next.done   = 1'b1;
          tok_next.is_new = 1'b1;
          tok_next.id     = vdr_pkg::id_t'(Idx);
        end else if (key == tok_in.key) begin
          tok_next.done   = 1'b1;
          tok_next.is_new = 1'b0;
          tok_next.id     = vdr_pkg::id_t'(Idx);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out  <= '0;
      occupied <= 1'b0;
    end else begin
      tok_out  <= tok_next;
      occupied <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (key_write) begin
      key <= tok_in.key;
    end
  end

  a_tok_moves: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid == $past(tok_in.valid && !rst))
    else $error("lookup lost or created in cell");

  a_hit_claims: assert property (@(posedge clk) disable iff (rst)
    tok_in.valid && !tok_in.done && occupied && !tok_in.clear && key == tok_in.key
    |=> tok_out.done && !tok_out.is_new && tok_out.id == vdr_pkg::id_t'(Idx))
    else $error("matching cell did not claim lookup");

  a_insert_fills: assert property (@(posedge clk) disable iff (rst)
    key_write |=> occupied && tok_out.is_new && key == $past(tok_in.key))
    else $error("insert did not fill cell");

endmodule

/* dv/vertex_dedup_index_remap_tb.sv */
class remap_scoreboard;
  vdr_pkg::key_t    mesh_keys [vdr_pkg::MAX_VERTICES];
  int unsigned      key_count;
  vdr_pkg::result_t remap_q[$];
  int unsigned      mismatches;

  function new();
    key_count  = 0;
    mismatches = 0;
  endfunction

  // Fold -0 onto +0 so that stored keys compare bit for bit.
  function logic [31:0] fold_zero(logic [31:0] c);
    if (c[30:0] == 31'd0) begin
      return 32'd0;
    end
    return c;
  endfunction

  function void note_item(vdr_pkg::item_t it);
    vdr_pkg::key_t    k;
    vdr_pkg::result_t r;
    bit               hit;
    k   = {fold_zero(it.vertex_x), fold_zero(it.vertex_y), fold_zero(it.vertex_z)};
    r   = '0;
    hit = 1'b0;
    if (it.first_of_mesh) begin
      key_count = 0;
    end
    for (int unsigned i = 0; i < key_count; i++) begin
      if (!hit && mesh_keys[i] == k) begin
        hit         = 1'b1;
        r.merged_id = vdr_pkg::MERGED_ID_W'(i);
      end
    end
    if (!hit) begin
      if (key_count >= vdr_pkg::MAX_VERTICES) begin
        r.overflow = 1'b1;
      end else begin
        mesh_keys[key_count] = k;
        r.merged_id  = vdr_pkg::MERGED_ID_W'(key_count);
        r.is_new     = 1'b1;
        r.kept_index = it.source_index;
        key_count++;
      end
    end
    remap_q.insert(remap_q.size(), r);
  endfunction

  function void check_result(vdr_pkg::result_t got);
    vdr_pkg::result_t exp_r;
    if (remap_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: id=%0d new=%0b kept=%06h ovf=%0b",
                 got.merged_id, got.is_new, got.kept_index, got.overflow);
      end
      return;
    end
    exp_r = remap_q.pop_front();
    if (got.merged_id !== exp_r.merged_id || got.is_new !== exp_r.is_new ||
        got.kept_index !== exp_r.kept_index || got.overflow !== exp_r.overflow) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp id/new/kept/ovf=%0d/%0b/%06h/%0b got %0d/%0b/%06h/%0b",
                 exp_r.merged_id, exp_r.is_new, exp_r.kept_index, exp_r.overflow,
                 got.merged_id, got.is_new, got.kept_index, got.overflow);
      end
    end
  endfunction

  function int unsigned outstanding();
    return remap_q.size();
  endfunction
endclass

module vertex_dedup_index_remap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY     = vdr_pkg::MAX_VERTICES + 1;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam logic [31:0] SPECIAL_COORDS [8] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h3F80_0000
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  vdr_pkg::item_t   item = '0;
  logic             busy;
  logic             strobe;
  vdr_pkg::result_t result;

  remap_scoreboard sb = new();
  int unsigned     items_sent = 0;

  vertex_dedup_index_remap #(
    .MaxVertices(vdr_pkg::MAX_VERTICES)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .strobe(strobe),
    .result(result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && busy === 1'b0) begin
        sb.note_item(item);
      end
      if (strobe === 1'b1) begin
        sb.check_result(result);
      end
    end
  end

  function automatic logic [31:0] random_coord();
    if ($urandom_range(0, 9) < 2) begin
      return SPECIAL_COORDS[$urandom_range(0, 7)];
    end
    return $urandom();
  endfunction

  // Either sign of zero must hit the same entry.
  function automatic logic [31:0] flip_zero_sign(logic [31:0] c);
    if (c[30:0] == 31'd0) begin
      c[31] = 1'($urandom_range(0, 1));
    end
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic vdr_pkg::item_t make_item(logic fom, logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [23:0] src);
    vdr_pkg::item_t it;
    it.first_of_mesh = fom;
    it.vertex_x      = x;
    it.vertex_y      = y;
    it.vertex_z      = z;
    it.source_index  = src;
    return it;
  endfunction

  // Hold start until the transfer happens, then optionally idle with noise on item.
  task automatic send_item(input vdr_pkg::item_t it, input int unsigned gap);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    items_sent++;
    if (gap != 0) begin
      start <= 1'b0;
      item  <= make_item(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
                         24'($urandom_range(0, 24'hFFFFFF)));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_mesh(input int unsigned n_items, input int unsigned new_pct,
                          input bit no_gaps, input int unsigned clear_pct);
    vdr_pkg::key_t  pool[$];
    vdr_pkg::key_t  k;
    vdr_pkg::item_t it;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (pool.size() == 0 || $urandom_range(0, 99) < new_pct) begin
        if (pool.size() != 0 && $urandom_range(0, 3) == 0) begin
          // near miss: two coordinates shared with a known vertex
          k = pool[$urandom_range(0, pool.size() - 1)];
          case ($urandom_range(0, 2))
            0:       k[95:64] = random_coord();
            1:       k[63:32] = random_coord();
            default: k[31:0]  = random_coord();
          endcase
        end else begin
          k = {random_coord(), random_coord(), random_coord()};
        end
        pool.insert(pool.size(), k);
      end else begin
        k = pool[$urandom_range(0, pool.size() - 1)];
      end
      it = make_item((i == 0) || ($urandom_range(0, 99) < clear_pct),
                     flip_zero_sign(k[95:64]), flip_zero_sign(k[63:32]),
                     flip_zero_sign(k[31:0]), 24'($urandom_range(0, 24'hFFFFFF)));
      send_item(it, no_gaps ? 0 : pick_gap());
    end
  endtask

  initial begin
    #5_000_000;
    $display("FAIL vertex_dedup_index_remap");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // signed zeros, NaN patterns, near misses, store clears
    send_item(make_item(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 24'hFFFFFF), 0);
    send_item(make_item(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h000000), 0);
    send_item(make_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h000001), 1);
    send_item(make_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h800000), 0);
    send_item(make_item(1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h123456), 0);
    send_item(make_item(1'b0, 32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000, 24'h654321), 2);
    send_item(make_item(1'b0, 32'h3F80_0000, 32'h0000_0000, 32'h8000_0000, 24'hAAAAAA), 0);
    send_item(make_item(1'b0, 32'h3F80_0000, 32'h8000_0000, 32'h0000_0000, 24'h555555), 0);
    send_item(make_item(1'b0, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0001, 24'h0F0F0F), 0);
    send_item(make_item(1'b0, 32'hBF80_0000, 32'h0000_0000, 32'h8000_0000, 24'hF0F0F0), 5);
    send_item(make_item(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 24'hAAAAAA), 0);
    send_item(make_item(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 24'h555555), 0);
    send_item(make_item(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 24'h000002), 0);
    send_item(make_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h7FFFFF), 0);
    send_item(make_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h000003), 0);
    send_item(make_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h000004), 0);
    send_item(make_item(1'b0, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 24'hFFFFFE), 0);
    send_item(make_item(1'b0, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 24'h000005), 0);
    drain();

    // fill the store past capacity, then keep hitting it
    run_mesh(1150, 97, 1'b0, 0);
    drain();

    while (items_sent < ITEM_TARGET) begin
      run_mesh($urandom_range(0, 7) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 30),
               $urandom_range(15, 75), $urandom_range(0, 3) == 0, 2);
    end
    drain();

    repeat (LATENCY + 16) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS vertex_dedup_index_remap");
    end else begin
      $display("FAIL vertex_dedup_index_remap");
    end
    $finish;
  end
endmodule
